>>> design/rgbtp_pkg.sv
// Package for the RGB triple text parser.
// Holds the parse phase type, character codes and the internal stage word type.
// Depends on nothing; every other source file uses it.
package rgbtp_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CompWidth  = 8;
  localparam int unsigned ColorWidth = 24;
  localparam int unsigned FieldWidth = 2;
  localparam int unsigned ProdWidth  = 12;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharComma = 8'h2C;

  localparam logic [ProdWidth-1:0]  CompMax   = 12'd255;
  localparam logic [FieldWidth-1:0] FieldLast = 2'd2;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_DIGITS = 2'd1,
    PH_AFTER  = 2'd2
  } phase_e;

  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] ch;
    logic                 string_end;
  } stage_word_t;

endpackage

>>> design/rgbtp_char_if.sv
// Channel interface for the character words entering the parser.
// Depends on rgbtp_pkg for the character width.
interface rgbtp_char_if;
  logic                           valid;
  logic                           ready;
  logic [rgbtp_pkg::CharWidth-1:0] ch;
  logic                           string_end;

  modport source (output valid, ch, string_end, input ready);
  modport sink (input valid, ch, string_end, output ready);
endinterface

>>> design/rgbtp_color_if.sv
// Channel interface for the result words leaving the parser.
// Depends on rgbtp_pkg for the colour width.
interface rgbtp_color_if;
  logic                            valid;
  logic                            ready;
  logic                            valid_res;
  logic [rgbtp_pkg::ColorWidth-1:0] color;

  modport source (output valid, valid_res, color, input ready);
  modport sink (input valid, valid_res, color, output ready);
endinterface

>>> design/rgbtp_in_stage.sv
// Input register of the parser: captures one character word per cycle while the parse core takes them.
// Depends on rgbtp_pkg and rgbtp_char_if.
module rgbtp_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rgbtp_char_if.sink            char_i,
  input  logic                  take_i,
  output rgbtp_pkg::stage_word_t stage_o
);
  import rgbtp_pkg::*;

  logic                 valid_q, valid_d;
  logic [CharWidth-1:0] ch_q;
  logic                 end_q;
  logic                 load;

  assign char_i.ready = !valid_q || take_i;
  assign load         = char_i.valid && char_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q  <= char_i.ch;
      end_q <= char_i.string_end;
    end
  end

  assign stage_o.valid      = valid_q;
  assign stage_o.ch         = ch_q;
  assign stage_o.string_end = end_q;

endmodule

>>> design/rgbtp_parse_core.sv
// Parse state, one-step update logic and the result register.
// Depends on rgbtp_pkg and rgbtp_color_if.
module rgbtp_parse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbtp_pkg::stage_word_t stage_i,
  output logic                  take_o,
  rgbtp_color_if.source         color_o
);
  import rgbtp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [FieldWidth-1:0] field_q, field_d;
  logic [CompWidth-1:0]  acc_q, acc_d;
  logic                  failed_q, failed_d;
  logic [CompWidth-1:0]  red_q, red_d;
  logic [CompWidth-1:0]  green_q, green_d;
  logic                  out_valid_q, out_valid_d;
  logic                  res_ok_q, res_ok_d;
  logic [ColorWidth-1:0] color_q, color_d;

  logic                  is_digit;
  logic [ProdWidth-1:0]  digit;
  logic [ProdWidth-1:0]  acc_ext;
  logic [ProdWidth-1:0]  next_val;
  logic                  take_end;

  assign take_o   = stage_i.valid
                    && (!stage_i.string_end || !out_valid_q || color_o.ready);
  assign take_end = take_o && stage_i.string_end;

  assign is_digit = (stage_i.ch >= CharZero) && (stage_i.ch <= CharNine);
  assign digit    = ProdWidth'(stage_i.ch - CharZero);
  assign acc_ext  = ProdWidth'(acc_q);
  assign next_val = (phase_q == PH_DIGITS)
                    ? ((acc_ext << 3) + (acc_ext << 1) + digit) : digit;

  always_comb begin
    phase_d  = phase_q;
    field_d  = field_q;
    acc_d    = acc_q;
    failed_d = failed_q;
    red_d    = red_q;
    green_d  = green_q;
    res_ok_d = res_ok_q;
    color_d  = color_q;
    if (take_end) begin
      res_ok_d = !failed_q && (field_q == FieldLast) && (phase_q != PH_BEFORE);
      color_d  = res_ok_d ? {red_q, green_q, acc_q} : '0;
      phase_d  = PH_BEFORE;
      field_d  = '0;
      acc_d    = '0;
      failed_d = 1'b0;
      red_d    = '0;
      green_d  = '0;
    end else if (take_o && !failed_q) begin
      if (is_digit) begin
        if (phase_q != PH_BEFORE && phase_q != PH_DIGITS) begin
          failed_d = 1'b1;
        end else if (next_val > CompMax) begin
          failed_d = 1'b1;
        end else begin
          acc_d   = next_val[CompWidth-1:0];
          phase_d = PH_DIGITS;
        end
      end else if (stage_i.ch == CharSpace) begin
        if (phase_q == PH_DIGITS) begin
          phase_d = PH_AFTER;
        end
      end else if (stage_i.ch == CharComma) begin
        if (phase_q == PH_BEFORE || field_q >= FieldLast) begin
          failed_d = 1'b1;
        end else begin
          if (field_q == '0) begin
            red_d = acc_q;
          end else begin
            green_d = acc_q;
          end
          field_d = field_q + FieldWidth'(1);
          acc_d   = '0;
          phase_d = PH_BEFORE;
        end
      end else begin
        failed_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_end) begin
      out_valid_d = 1'b1;
    end else if (color_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BEFORE;
      field_q     <= '0;
      acc_q       <= '0;
      failed_q    <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      field_q     <= field_d;
      acc_q       <= acc_d;
      failed_q    <= failed_d;
      red_q       <= red_d;
      green_q     <= green_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q <= res_ok_d;
    color_q  <= color_d;
  end

  assign color_o.valid     = out_valid_q;
  assign color_o.valid_res = res_ok_q;
  assign color_o.color     = color_q;

endmodule

>>> design/rgb_triple_text_parser_unit.sv
// RGB triple text parser: reads r,g,b one character word per cycle unless a waiting result stalls a terminator.
// A terminator word's result word passes through the input register and then the result register.
// Throughput: one word per cycle; the input register and result register decouple
// the two channels, so a waiting result stalls only a following terminator.
// Reset (asynchronous, active low) empties both registers and clears the parse state.
// Depends on rgbtp_pkg, rgbtp_char_if, rgbtp_color_if, rgbtp_in_stage, rgbtp_parse_core.
module rgb_triple_text_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgbtp_char_if.sink    char_i,
  rgbtp_color_if.source color_o
);
  import rgbtp_pkg::*;

  stage_word_t stage;
  logic        take;

  rgbtp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .take_i  (take),
    .stage_o (stage)
  );

  rgbtp_parse_core u_parse_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .color_o (color_o)
  );

`ifndef NO_ASSERTIONS
  a_result_from_terminator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(color_o.valid) |-> $past(take && stage.string_end))
    else $error("Result word appeared without a terminator being consumed.");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage.valid && !take) |=> (stage.valid && $stable(stage.ch)
                                && $stable(stage.string_end)))
    else $error("Input register lost or changed an unconsumed word.");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage.valid |-> char_i.ready)
    else $error("Input not ready although the input register is empty.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_o.valid && !color_o.valid_res) |-> (color_o.color == '0))
    else $error("Invalid result carries a non-zero colour.");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for rgb_triple_text_parser_unit: sends r,g,b texts one character
// word at a time and checks every colour word against a built-in parser model.
// Depends on rgbtp_pkg, rgbtp_char_if, rgbtp_color_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import rgbtp_pkg::*;

  localparam int unsigned IdlePct     = 31;
  localparam int unsigned RandomWords = 1150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned WatchdogNs  = 3_000_000;

  typedef struct packed {
    logic                  valid_res;
    logic [ColorWidth-1:0] color;
  } color_word_t;

  typedef struct {
    phase_e                phase;
    logic [FieldWidth-1:0] field;
    logic [CompWidth-1:0]  acc;
    logic                  failed;
    logic [CompWidth-1:0]  red;
    logic [CompWidth-1:0]  green;
  } parse_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rgbtp_char_if  char_bus ();
  rgbtp_color_if color_bus ();

  rgb_triple_text_parser_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_bus),
    .color_o (color_bus)
  );

  parse_state_t  parser;
  color_word_t   expected_colors[$];
  byte unsigned  draft_text[$];
  int unsigned   mismatch_count;
  int unsigned   words_sent;
  bit            quiet_mode;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_parser();
    parser.phase  = PH_BEFORE;
    parser.field  = '0;
    parser.acc    = '0;
    parser.failed = 1'b0;
    parser.red    = '0;
    parser.green  = '0;
  endfunction

  function automatic void absorb_char(logic [CharWidth-1:0] c);
    int unsigned value;
    if (parser.failed) return;
    if (c >= CharZero && c <= CharNine) begin
      if (parser.phase != PH_BEFORE && parser.phase != PH_DIGITS) begin
        parser.failed = 1'b1;
        return;
      end
      value = c - CharZero;
      if (parser.phase == PH_DIGITS) value = value + parser.acc * 10;
      if (value > CompMax) begin
        parser.failed = 1'b1;
        return;
      end
      parser.acc   = value[CompWidth-1:0];
      parser.phase = PH_DIGITS;
    end else if (c == CharSpace) begin
      if (parser.phase == PH_DIGITS) parser.phase = PH_AFTER;
    end else if (c == CharComma) begin
      if (parser.phase == PH_BEFORE || parser.field >= FieldLast) begin
        parser.failed = 1'b1;
        return;
      end
      if (parser.field == '0) parser.red = parser.acc;
      else parser.green = parser.acc;
      parser.field = parser.field + 1'b1;
      parser.acc   = '0;
      parser.phase = PH_BEFORE;
    end else begin
      parser.failed = 1'b1;
    end
  endfunction

  function automatic color_word_t close_text();
    color_word_t word;
    word.valid_res = !parser.failed && parser.field == FieldLast && parser.phase != PH_BEFORE;
    word.color     = word.valid_res ? {parser.red, parser.green, parser.acc} : '0;
    clear_parser();
    return word;
  endfunction

  task automatic send_word(input logic [CharWidth-1:0] c, input logic term);
    if (!quiet_mode && $urandom_range(99) < IdlePct) begin
      char_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    char_bus.valid      <= 1'b1;
    char_bus.ch         <= c;
    char_bus.string_end <= term;
    do @(posedge clk_i); while (!char_bus.ready);
    if (term) expected_colors.push_back(close_text());
    else absorb_char(c);
    words_sent++;
  endtask

  task automatic send_text();
    foreach (draft_text[i]) send_word(draft_text[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_string(input string s);
    draft_text.delete();
    for (int i = 0; i < s.len(); i++) draft_text.push_back(s[i]);
    send_text();
  endtask

  function automatic int unsigned pick_pad();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic int unsigned pick_component();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic void append_component(int unsigned value);
    string digits;
    digits = $sformatf("%0d", value);
    repeat (pick_pad()) draft_text.push_back(CharSpace);
    repeat (($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0) draft_text.push_back(CharZero);
    for (int i = 0; i < digits.len(); i++) draft_text.push_back(digits[i]);
    repeat (pick_pad()) draft_text.push_back(CharSpace);
  endfunction

  // Mostly well-formed texts; the rest have a wrong field count, an empty field,
  // an oversized value, a stray character or plain random bytes.
  function automatic void make_random_text();
    int unsigned  kind;
    int unsigned  fields;
    int unsigned  over_field;
    byte unsigned stray;
    draft_text.delete();
    kind       = $urandom_range(99);
    fields     = 3;
    over_field = $urandom_range(2);
    if (kind >= 70 && kind < 80) fields = $urandom_range(1) ? 4 : $urandom_range(1, 2);
    for (int f = 0; f < fields; f++) begin
      if (f != 0) draft_text.push_back(CharComma);
      if (kind >= 70 && kind < 80 && $urandom_range(4) == 0) begin
        repeat (pick_pad()) draft_text.push_back(CharSpace);
      end else if (kind >= 80 && kind < 90 && f == over_field) begin
        append_component($urandom_range(256, 99999));
      end else begin
        append_component(pick_component());
      end
    end
    if (kind >= 90) begin
      if ($urandom_range(3) == 0) begin
        draft_text.delete();
        repeat ($urandom_range(8)) draft_text.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(3))
          0:       stray = CharSpace;
          1:       stray = CharComma;
          2:       stray = CharZero + $urandom_range(9);
          default: stray = $urandom_range(255);
        endcase
        draft_text.insert($urandom_range(draft_text.size() - 1), stray);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && color_bus.valid && color_bus.ready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected colour word valid_res=%0b color=%06h", $time,
                 color_bus.valid_res, color_bus.color);
        mismatch_count++;
      end else begin
        if (color_bus.valid_res !== expected_colors[0].valid_res) begin
          $display("%0t: valid_res expected %0b actual %0b", $time,
                   expected_colors[0].valid_res, color_bus.valid_res);
          mismatch_count++;
        end
        if (color_bus.color !== expected_colors[0].color) begin
          $display("%0t: color expected %06h actual %06h", $time,
                   expected_colors[0].color, color_bus.color);
          mismatch_count++;
        end
        void'(expected_colors.pop_front());
      end
    end
    color_bus.ready <= quiet_mode || ($urandom_range(99) >= IdlePct);
  end

  task automatic test_well_formed();
    send_string("0,0,0");
    send_string("255,255,255");
    send_string(" 007 ,  08,9 ");
    send_string("1,2,3 ");
  endtask

  task automatic test_malformed();
    send_string("");
    send_string(",1,2");
    send_string("1,,2");
    send_string("1,2,");
    send_string("1,2");
    send_string("1,2,3,4");
    send_string("1,2 3,4");
    send_string("256,0,0");
    send_string("255,255,2550");
    send_string("x,1,2");
    draft_text = '{8'h31, CharComma, 8'h32, CharComma, 8'h00};
    send_text();
    draft_text = '{8'hFF, 8'h31, CharComma, 8'h32, CharComma, 8'h33};
    send_text();
  endtask

  task automatic test_random_texts();
    while (words_sent < RandomWords) begin
      quiet_mode = (words_sent > 400 && words_sent < 650);
      make_random_text();
      send_text();
    end
    quiet_mode = 1'b0;
  endtask

  task automatic finish_run();
    char_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  endtask

  initial begin
    mismatch_count      = 0;
    words_sent          = 0;
    quiet_mode          = 1'b0;
    rst_ni              = 1'b0;
    char_bus.valid      = 1'b0;
    char_bus.ch         = '0;
    char_bus.string_end = 1'b0;
    color_bus.ready     = 1'b0;
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_well_formed();
    test_malformed();
    test_random_texts();
    finish_run();
  end

  initial begin
    #(WatchdogNs);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
design/rgbtp_pkg.sv
design/rgbtp_char_if.sv
design/rgbtp_color_if.sv
design/rgbtp_in_stage.sv
design/rgbtp_parse_core.sv
design/rgb_triple_text_parser_unit.sv
sim/tb_top.sv
